[design/t0pc_pkg.sv]
package t0pc_pkg;

    localparam int COUNT_W     = 8;
    localparam int PRESCALE_W  = 8;
    localparam int RATIO_W     = PRESCALE_W + 1;
    localparam int HOLD_W      = 2;
    localparam int RATE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [HOLD_W-1:0]  SYNC_TICKS = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hff;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXTERNAL_CLOCK   = 2'd0,
        CFG_PRESCALER_BYPASS = 2'd1,
        CFG_PRESCALE_RATE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic              external_clock;
        logic              prescaler_bypass;
        logic [RATE_W-1:0] prescale_rate;
    } t_cfg;

endpackage

[design/t0pc_in_if.sv]
interface t0pc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] write_data;

    modport source (output valid, output req_type, output write_data, input ready);
    modport sink   (input valid, input req_type, input write_data, output ready);
endinterface

[design/t0pc_out_if.sv]
interface t0pc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] count_value;
    logic       overflow;

    modport source (output valid, output count_value, output overflow, input ready);
    modport sink   (input valid, input count_value, input overflow, output ready);
endinterface

[design/t0pc_cfg_if.sv]
interface t0pc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [2:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/t0pc_cfg.sv]
module t0pc_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    t0pc_cfg_if.sink        i_cfg,
    output t0pc_pkg::t_cfg  o_cfg,
    output logic            o_cfg_clear
);

    t0pc_pkg::t_cfg r_cfg;
    t0pc_pkg::t_cfg n_cfg;
    logic           n_clear;
    logic           wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_cfg   = r_cfg;
        n_clear = 1'b0;
        if (wr) begin
            unique case (t0pc_pkg::t_cfg_idx'(i_cfg.index))
                t0pc_pkg::CFG_EXTERNAL_CLOCK: begin
                    n_cfg.external_clock = i_cfg.data[0];
                    n_clear              = 1'b1;
                end
                t0pc_pkg::CFG_PRESCALER_BYPASS: begin
                    n_cfg.prescaler_bypass = i_cfg.data[0];
                    n_clear                = 1'b1;
                end
                t0pc_pkg::CFG_PRESCALE_RATE: begin
                    n_cfg.prescale_rate = i_cfg.data[t0pc_pkg::RATE_W-1:0];
                    n_clear             = 1'b1;
                end
                default: begin
                    n_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.external_clock   <= 1'b1;
            r_cfg.prescaler_bypass <= 1'b1;
            r_cfg.prescale_rate    <= 3'd7;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg       = r_cfg;
    assign o_cfg_clear = n_clear;

endmodule

[design/t0pc_core.sv]
module t0pc_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t0pc_pkg::t_cfg                    i_cfg,
    input  logic                              i_cfg_clear,
    input  logic                              i_step,
    input  logic [1:0]                        i_req_type,
    input  logic [t0pc_pkg::COUNT_W-1:0]      i_write_data,
    output logic [t0pc_pkg::COUNT_W-1:0]      o_count_value,
    output logic                              o_overflow
);

    logic [t0pc_pkg::COUNT_W-1:0]    r_count;
    logic [t0pc_pkg::PRESCALE_W-1:0] r_prescale_count;
    logic [t0pc_pkg::HOLD_W-1:0]     r_sync_hold;
    logic [t0pc_pkg::COUNT_W-1:0]    n_count;
    logic [t0pc_pkg::PRESCALE_W-1:0] n_prescale_count;
    logic [t0pc_pkg::HOLD_W-1:0]     n_sync_hold;
    logic [t0pc_pkg::RATIO_W-1:0]    ratio;
    logic [t0pc_pkg::RATIO_W-1:0]    pre_next;
    logic                            advance;
    logic                            ovf;
    t0pc_pkg::t_req                  req;

    assign req      = t0pc_pkg::t_req'(i_req_type);
    assign ratio    = i_cfg.prescaler_bypass ? t0pc_pkg::RATIO_W'(1)
                    : t0pc_pkg::RATIO_W'(2) << i_cfg.prescale_rate;
    assign pre_next = {1'b0, r_prescale_count} + t0pc_pkg::RATIO_W'(1);

    always_comb begin
        n_count          = r_count;
        n_prescale_count = r_prescale_count;
        n_sync_hold      = r_sync_hold;
        advance          = 1'b0;
        ovf              = 1'b0;
        if (i_cfg_clear) begin
            n_prescale_count = '0;
        end else if (i_step) begin
            unique case (req)
                t0pc_pkg::REQ_TICK: begin
                    if (r_sync_hold != '0) begin
                        n_sync_hold = r_sync_hold - t0pc_pkg::HOLD_W'(1);
                    end else begin
                        advance = !i_cfg.external_clock;
                    end
                end
                t0pc_pkg::REQ_EDGE: begin
                    advance = i_cfg.external_clock;
                end
                t0pc_pkg::REQ_WRITE: begin
                    n_count          = i_write_data;
                    n_prescale_count = '0;
                    n_sync_hold      = t0pc_pkg::SYNC_TICKS;
                end
                t0pc_pkg::REQ_READ: begin
                    n_count = r_count;
                end
            endcase
            if (advance) begin
                if (pre_next < ratio) begin
                    n_prescale_count = pre_next[t0pc_pkg::PRESCALE_W-1:0];
                end else begin
                    n_prescale_count = '0;
                    n_count          = r_count + t0pc_pkg::COUNT_W'(1);
                    ovf              = (r_count == t0pc_pkg::COUNT_MAX);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count          <= '0;
            r_prescale_count <= '0;
            r_sync_hold      <= '0;
        end else begin
            r_count          <= n_count;
            r_prescale_count <= n_prescale_count;
            r_sync_hold      <= n_sync_hold;
        end
    end

    assign o_count_value = n_count;
    assign o_overflow    = ovf;

    a_ovf_wraps_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_overflow) |-> (o_count_value == '0))
        else $error("overflow reported without the count wrapping to zero");

    a_write_sets_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_cfg_clear && req == t0pc_pkg::REQ_WRITE)
        |=> (r_sync_hold == t0pc_pkg::SYNC_TICKS && r_prescale_count == '0))
        else $error("write did not restart the synchronisation hold");

    a_hold_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sync_hold <= t0pc_pkg::SYNC_TICKS)
        else $error("synchronisation hold above its load value");

    a_prescale_below_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_prescale_count} < ratio)
        else $error("prescaler count reached the division ratio");

endmodule

[design/timer0_prescaled_counter_top.sv]
// An 8-bit timer with a selectable clock source and a power-of-two prescaler.
// Each transfer on the input channel is one event: an instruction-cycle tick,
// an external clock edge, a write of the count or a read of the count. Every
// input transfer gives exactly one output transfer carrying the count after
// the event and an overflow flag that is set when the count wrapped to zero.
// The configuration channel writes the clock source, the prescaler bypass
// and the prescale rate; it is always ready, and a write to one of these
// three registers clears the prescaler.
// Configuration should be written only while no event is in flight.
// An event is held in an input register and processed once the output
// register is free; its result is then held in the output register until
// the receiver takes it. One event is accepted in every cycle while the
// receiver does not stall.
// When the receiver stalls, the result stays in the output register and one
// further event is held in the input register before the input stalls too.
// After reset the count, prescaler and hold are zero, external edges are
// counted and the prescaler is bypassed.
module timer0_prescaled_counter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    t0pc_in_if.sink     i_in,
    t0pc_cfg_if.sink    i_cfg,
    t0pc_out_if.source  o_out
);

    t0pc_pkg::t_cfg                cfg;
    logic                          cfg_clear;
    logic                          r_in_valid;
    logic [1:0]                    r_in_req;
    logic [t0pc_pkg::COUNT_W-1:0]  r_in_data;
    logic                          r_out_valid;
    logic [t0pc_pkg::COUNT_W-1:0]  r_out_count;
    logic                          r_out_ovf;
    logic                          out_free;
    logic                          in_ready;
    logic                          step;
    logic [t0pc_pkg::COUNT_W-1:0]  res_count;
    logic                          res_ovf;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign in_ready   = !r_in_valid || out_free;
    assign i_in.ready = in_ready;

    t0pc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_cfg       (cfg),
        .o_cfg_clear (cfg_clear)
    );

    t0pc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cfg_clear   (cfg_clear),
        .i_step        (step),
        .i_req_type    (r_in_req),
        .i_write_data  (r_in_data),
        .o_count_value (res_count),
        .o_overflow    (res_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_req  <= i_in.req_type;
            r_in_data <= i_in.write_data;
        end
        if (step) begin
            r_out_count <= res_count;
            r_out_ovf   <= res_ovf;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.count_value = r_out_count;
    assign o_out.overflow    = r_out_ovf;

endmodule
